/* src/cia_pkg.sv */
`default_nettype none

package cia_pkg;

   localparam int MODE_W = 3;
   localparam int RES_W  = 32;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD = 3'd0,
      MODE_SUB = 3'd1,
      MODE_MUL = 3'd2,
      MODE_DIV = 3'd3,
      MODE_POW = 3'd4
   } mode_type;

endpackage

`default_nettype wire

/* src/cia_div.sv */
`default_nettype none

module cia_div #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [2*OPERAND_WIDTH-1:0]   dividend,
   input  logic [2*OPERAND_WIDTH-1:0]   divisor,
   output logic                         done,
   output logic [OPERAND_WIDTH:0]       quotient
);

   localparam int SW = 2 * OPERAND_WIDTH;
   localparam int QB = OPERAND_WIDTH + 1;
   localparam int CW = $clog2(QB + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [SW-1:0] dvs_ff, dvs_in;
   logic [QB-1:0] dsh_ff, dsh_in;

   logic [SW:0]   trial;
   logic [SW:0]   diff;
   logic          ge;

   // The quotient fits in QB bits, so the bits above them start as the remainder.
   assign trial = {rem_ff, dsh_ff[QB-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      dsh_in  = dsh_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(QB);
         rem_in  = SW'(dividend >> QB);
         dsh_in  = dividend[QB-1:0];
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[SW-1:0] : trial[SW-1:0];
         dsh_in = {dsh_ff[QB-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      dsh_ff <= dsh_in;
   end

   assign done     = done_ff;
   assign quotient = dsh_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_last_step_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == CW'(1)) |=> (done_ff && !busy_ff))
      else $error("divider missed its done beat");

endmodule

`default_nettype wire

/* src/complex_integer_alu.sv */
// Channel  Handshake                Payload
// req      req_valid / req_stall    req_mode, req_x_re, req_x_im, req_y_re, req_y_im,
//                                   req_exponent
// rsp      rsp_valid / rsp_stall    rsp_res_re, rsp_res_im, rsp_div_by_zero
//
// One beat is worked on at a time; req_stall is high from acceptance until the result
// is moved into the output register. All products go through one 32x32 multiplier:
// a complex product is four real products in turn. Add, subtract and unused codes go
// straight to the output register; multiply runs one complex product, divide two
// complex products, then two restoring divisions of OPERAND_WIDTH+1 steps each, or just
// the products if the divisor is zero; power is square-and-multiply, MSB first.
// Reset is synchronous and clears the sequencer and the output valid.
// A stalled result holds while the next beat is already accepted and worked on.
`default_nettype none

module complex_integer_alu #(
   parameter int OPERAND_WIDTH  = 16,
   parameter int EXPONENT_WIDTH = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [cia_pkg::MODE_W-1:0]        req_mode,
   input  logic signed [OPERAND_WIDTH-1:0]   req_x_re,
   input  logic signed [OPERAND_WIDTH-1:0]   req_x_im,
   input  logic signed [OPERAND_WIDTH-1:0]   req_y_re,
   input  logic signed [OPERAND_WIDTH-1:0]   req_y_im,
   input  logic [EXPONENT_WIDTH-1:0]         req_exponent,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [cia_pkg::RES_W-1:0]  rsp_res_re,
   output logic signed [cia_pkg::RES_W-1:0]  rsp_res_im,
   output logic                              rsp_div_by_zero
);

   import cia_pkg::*;

   localparam int SW    = 2 * OPERAND_WIDTH;
   localparam int QB    = OPERAND_WIDTH + 1;
   localparam int ACC_W = (SW + 1 > RES_W) ? SW + 1 : RES_W;
   localparam int EW    = EXPONENT_WIDTH;
   localparam int CW    = $clog2(EW + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_MDONE,
      S_DIV_RE,
      S_DIV_IM,
      S_POW_SCAN,
      S_POW_STEP,
      S_OUT
   } state_type;

   typedef enum logic [2:0] {
      PH_MUL,
      PH_DIV_S,
      PH_DIV_N,
      PH_POW_SQ,
      PH_POW_MX
   } phase_type;

   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [2:0]        k_ff, k_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              div_start_ff, div_start_in;

   logic [RES_W-1:0]  x_re_ff, x_re_in, x_im_ff, x_im_in;
   logic [RES_W-1:0]  p_re_ff, p_re_in, p_im_ff, p_im_in;
   logic [RES_W-1:0]  q_re_ff, q_re_in, q_im_ff, q_im_in;
   logic [RES_W-1:0]  r_re_ff, r_re_in, r_im_ff, r_im_in;
   logic              flag_ff, flag_in;
   logic [ACC_W-1:0]  prod_ff, prod_in;
   logic [ACC_W-1:0]  acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic [SW-1:0]     s_ff, s_in;
   logic [SW-1:0]     dvd_ff, dvd_in;
   logic              neg_ff, neg_in;
   logic [EW-1:0]     e_ff, e_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [RES_W-1:0]  rsp_re_ff, rsp_re_in, rsp_im_ff, rsp_im_in;
   logic              rsp_dz_ff, rsp_dz_in;

   logic [RES_W-1:0]  mul_a, mul_b;
   logic [2*RES_W-1:0] mul_full;
   logic [SW:0]       neg_num_re, neg_num_im;
   logic [SW-1:0]     mag_re, mag_im;
   logic              div_done;
   logic [QB-1:0]     div_quot;
   logic [RES_W-1:0]  quot_ext, quot_signed;
   logic [RES_W-1:0]  ax_re, ax_im, ay_re, ay_im;
   logic              small_exp;

   // Shared multiplier: one real product per cycle, in the order re*re, im*im, re*im, im*re.
   always_comb begin
      case (k_ff)
         3'd1:    begin mul_a = p_im_ff; mul_b = q_im_ff; end
         3'd2:    begin mul_a = p_re_ff; mul_b = q_im_ff; end
         3'd3:    begin mul_a = p_im_ff; mul_b = q_re_ff; end
         default: begin mul_a = p_re_ff; mul_b = q_re_ff; end
      endcase
   end

   assign mul_full = $signed(mul_a) * $signed(mul_b);
   assign prod_in  = mul_full[ACC_W-1:0];

   assign neg_num_re = -acc_re_ff[SW:0];
   assign neg_num_im = -acc_im_ff[SW:0];
   assign mag_re     = acc_re_ff[SW] ? neg_num_re[SW-1:0] : acc_re_ff[SW-1:0];
   assign mag_im     = acc_im_ff[SW] ? neg_num_im[SW-1:0] : acc_im_ff[SW-1:0];

   assign quot_ext    = RES_W'(div_quot);
   assign quot_signed = neg_ff ? -quot_ext : quot_ext;

   assign ax_re = RES_W'(req_x_re);
   assign ax_im = RES_W'(req_x_im);
   assign ay_re = RES_W'(req_y_re);
   assign ay_im = RES_W'(req_y_im);

   assign small_exp = (EW + 1)'(req_exponent) <= (EW + 1)'(1);

   cia_div #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start_ff),
      .dividend(dvd_ff),
      .divisor (s_ff),
      .done    (div_done),
      .quotient(div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      k_in         = k_ff;
      div_start_in = 1'b0;
      x_re_in      = x_re_ff;
      x_im_in      = x_im_ff;
      p_re_in      = p_re_ff;
      p_im_in      = p_im_ff;
      q_re_in      = q_re_ff;
      q_im_in      = q_im_ff;
      r_re_in      = r_re_ff;
      r_im_in      = r_im_ff;
      flag_in      = flag_ff;
      acc_re_in    = acc_re_ff;
      acc_im_in    = acc_im_ff;
      s_in         = s_ff;
      dvd_in       = dvd_ff;
      neg_in       = neg_ff;
      e_in         = e_ff;
      cnt_in       = cnt_ff;
      rsp_re_in    = rsp_re_ff;
      rsp_im_in    = rsp_im_ff;
      rsp_dz_in    = rsp_dz_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_re_in = ax_re;
               x_im_in = ax_im;
               flag_in = 1'b0;
               k_in    = 3'd0;
               r_re_in = '0;
               r_im_in = '0;
               state_in = S_OUT;
               case (mode_type'(req_mode))
                  MODE_ADD: begin
                     r_re_in = ax_re + ay_re;
                     r_im_in = ax_im + ay_im;
                  end
                  MODE_SUB: begin
                     r_re_in = ax_re - ay_re;
                     r_im_in = ax_im - ay_im;
                  end
                  MODE_MUL: begin
                     p_re_in  = ax_re;
                     p_im_in  = ax_im;
                     q_re_in  = ay_re;
                     q_im_in  = ay_im;
                     phase_in = PH_MUL;
                     state_in = S_MUL;
                  end
                  MODE_DIV: begin
                     // y times its conjugate gives the squared divisor magnitude c*c+d*d.
                     p_re_in  = ay_re;
                     p_im_in  = ay_im;
                     q_re_in  = ay_re;
                     q_im_in  = -ay_im;
                     phase_in = PH_DIV_S;
                     state_in = S_MUL;
                  end
                  MODE_POW: begin
                     r_re_in = ax_re;
                     r_im_in = ax_im;
                     e_in    = req_exponent;
                     cnt_in  = CW'(EW);
                     if (!small_exp) begin
                        state_in = S_POW_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MUL: begin
            k_in = k_ff + 3'd1;
            case (k_ff)
               3'd1:    acc_re_in = prod_ff;
               3'd2:    acc_re_in = acc_re_ff - prod_ff;
               3'd3:    acc_im_in = prod_ff;
               3'd4:    acc_im_in = acc_im_ff + prod_ff;
               default: begin
               end
            endcase
            if (k_ff == 3'd4) begin
               state_in = S_MDONE;
            end
         end
         S_MDONE: begin
            k_in = 3'd0;
            unique case (phase_ff)
               PH_MUL: begin
                  r_re_in  = acc_re_ff[RES_W-1:0];
                  r_im_in  = acc_im_ff[RES_W-1:0];
                  state_in = S_OUT;
               end
               PH_DIV_S: begin
                  // The conjugate of y stays in q; x times it gives both numerators.
                  s_in     = acc_re_ff[SW-1:0];
                  p_re_in  = x_re_ff;
                  p_im_in  = x_im_ff;
                  phase_in = PH_DIV_N;
                  state_in = S_MUL;
               end
               PH_DIV_N: begin
                  if (s_ff == '0) begin
                     flag_in  = 1'b1;
                     state_in = S_OUT;
                  end else begin
                     dvd_in       = mag_re;
                     neg_in       = acc_re_ff[SW];
                     div_start_in = 1'b1;
                     state_in     = S_DIV_RE;
                  end
               end
               PH_POW_SQ: begin
                  r_re_in = acc_re_ff[RES_W-1:0];
                  r_im_in = acc_im_ff[RES_W-1:0];
                  if (e_ff[EW-1]) begin
                     p_re_in  = acc_re_ff[RES_W-1:0];
                     p_im_in  = acc_im_ff[RES_W-1:0];
                     q_re_in  = x_re_ff;
                     q_im_in  = x_im_ff;
                     phase_in = PH_POW_MX;
                     state_in = S_MUL;
                  end else begin
                     e_in     = e_ff << 1;
                     cnt_in   = cnt_ff - CW'(1);
                     state_in = S_POW_STEP;
                  end
               end
               PH_POW_MX: begin
                  r_re_in  = acc_re_ff[RES_W-1:0];
                  r_im_in  = acc_im_ff[RES_W-1:0];
                  e_in     = e_ff << 1;
                  cnt_in   = cnt_ff - CW'(1);
                  state_in = S_POW_STEP;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_DIV_RE: begin
            if (div_done) begin
               r_re_in      = quot_signed;
               dvd_in       = mag_im;
               neg_in       = acc_im_ff[SW];
               div_start_in = 1'b1;
               state_in     = S_DIV_IM;
            end
         end
         S_DIV_IM: begin
            if (div_done) begin
               r_im_in  = quot_signed;
               state_in = S_OUT;
            end
         end
         S_POW_SCAN: begin
            // Drop leading zeros and the leading one; r already holds x.
            e_in   = e_ff << 1;
            cnt_in = cnt_ff - CW'(1);
            if (e_ff[EW-1]) begin
               state_in = S_POW_STEP;
            end
         end
         S_POW_STEP: begin
            if (cnt_ff == '0) begin
               state_in = S_OUT;
            end else begin
               p_re_in  = r_re_ff;
               p_im_in  = r_im_ff;
               q_re_in  = r_re_ff;
               q_im_in  = r_im_ff;
               k_in     = 3'd0;
               phase_in = PH_POW_SQ;
               state_in = S_MUL;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_re_in    = r_re_ff;
               rsp_im_in    = r_im_ff;
               rsp_dz_in    = flag_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_MUL;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         div_start_ff <= div_start_in;
         cnt_ff       <= cnt_in;
      end
      x_re_ff   <= x_re_in;
      x_im_ff   <= x_im_in;
      p_re_ff   <= p_re_in;
      p_im_ff   <= p_im_in;
      q_re_ff   <= q_re_in;
      q_im_ff   <= q_im_in;
      r_re_ff   <= r_re_in;
      r_im_ff   <= r_im_in;
      flag_ff   <= flag_in;
      prod_ff   <= prod_in;
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
      s_ff      <= s_in;
      dvd_ff    <= dvd_in;
      neg_ff    <= neg_in;
      e_ff      <= e_in;
      rsp_re_ff <= rsp_re_in;
      rsp_im_ff <= rsp_im_in;
      rsp_dz_ff <= rsp_dz_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_res_re      = rsp_re_ff;
   assign rsp_res_im      = rsp_im_ff;
   assign rsp_div_by_zero = rsp_dz_ff;

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_dz_ff) |-> (rsp_re_ff == '0 && rsp_im_ff == '0))
      else $error("divide-by-zero beat carries a nonzero result");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV_RE || state_ff == S_DIV_IM))
      else $error("divider finished outside a divide step");

   a_mul_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> (k_ff <= 3'd4))
      else $error("multiply step count ran past four products");

endmodule

`default_nettype wire

/* tb/sv/complex_integer_alu_test.sv */
`timescale 1ns / 1ps

module complex_integer_alu_test;
   import cia_pkg::*;

   localparam int OPERAND_W   = 16;
   localparam int EXP_W       = 8;
   localparam int RANDOM_BEATS = 1050;
   localparam int PHASE_LEN   = 150;
   localparam int DRAIN_CYCLES = 150;

   localparam logic [MODE_W-1:0] MODE_RSVD_FIRST = 3'd5;
   localparam logic [MODE_W-1:0] MODE_RSVD_LAST  = 3'd7;

   localparam logic signed [OPERAND_W-1:0] OP_MAX = 16'sh7fff;
   localparam logic signed [OPERAND_W-1:0] OP_MIN = 16'sh8000;

   typedef struct {
      logic [MODE_W-1:0]             mode;
      logic signed [OPERAND_W-1:0]   x_re;
      logic signed [OPERAND_W-1:0]   x_im;
      logic signed [OPERAND_W-1:0]   y_re;
      logic signed [OPERAND_W-1:0]   y_im;
      logic [EXP_W-1:0]              exponent;
      bit                            drain_first;
   } alu_request_type;

   typedef struct {
      logic signed [RES_W-1:0] re;
      logic signed [RES_W-1:0] im;
      logic                    div_by_zero;
   } alu_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [MODE_W-1:0]             req_mode = '0;
   logic signed [OPERAND_W-1:0]   req_x_re = '0;
   logic signed [OPERAND_W-1:0]   req_x_im = '0;
   logic signed [OPERAND_W-1:0]   req_y_re = '0;
   logic signed [OPERAND_W-1:0]   req_y_im = '0;
   logic [EXP_W-1:0]              req_exponent = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [RES_W-1:0]       rsp_res_re;
   logic signed [RES_W-1:0]       rsp_res_im;
   logic                          rsp_div_by_zero;

   alu_request_type pending_requests[$];
   alu_result_type  expected_results[$];
   alu_request_type current_request;
   int           issued_count = 0;
   int           returned_count = 0;
   bit           failed = 1'b0;

   complex_integer_alu #(
      .OPERAND_WIDTH(OPERAND_W),
      .EXPONENT_WIDTH(EXP_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_x_re(req_x_re),
      .req_x_im(req_x_im),
      .req_y_re(req_y_re),
      .req_y_im(req_y_im),
      .req_exponent(req_exponent),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_res_re(rsp_res_re),
      .rsp_res_im(rsp_res_im),
      .rsp_div_by_zero(rsp_div_by_zero)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Complex product with every part wrapping at 32 bits.
   function automatic void complex_mul32(input logic [31:0] a, b, c, d,
                                         output logic [31:0] re, im);
      re = a * c - b * d;
      im = a * d + b * c;
   endfunction

   function automatic alu_result_type predict_alu(alu_request_type rq);
      longint      a, b, c, d, s;
      logic [31:0] ua, ub, uc, ud, re, im, nr, ni;
      int          i;
      alu_result_type r;
      a = rq.x_re;
      b = rq.x_im;
      c = rq.y_re;
      d = rq.y_im;
      ua = a[31:0];
      ub = b[31:0];
      uc = c[31:0];
      ud = d[31:0];
      re = '0;
      im = '0;
      r.div_by_zero = 1'b0;
      case (rq.mode)
         MODE_ADD: begin
            re = ua + uc;
            im = ub + ud;
         end
         MODE_SUB: begin
            re = ua - uc;
            im = ub - ud;
         end
         MODE_MUL: complex_mul32(ua, ub, uc, ud, re, im);
         MODE_DIV: begin
            s = c * c + d * d;
            if (s == 0) begin
               r.div_by_zero = 1'b1;
            end else begin
               // Signed 64-bit division truncates toward zero.
               a = (rq.x_re * c + rq.x_im * d) / s;
               b = (rq.x_im * c - rq.x_re * d) / s;
               re = a[31:0];
               im = b[31:0];
            end
         end
         MODE_POW: begin
            re = ua;
            im = ub;
            for (i = 1; i < rq.exponent; i++) begin
               complex_mul32(re, im, ua, ub, nr, ni);
               re = nr;
               im = ni;
            end
         end
         default: ;
      endcase
      r.re = re;
      r.im = im;
      return r;
   endfunction

   function automatic logic signed [OPERAND_W-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return OP_MIN;
         1: return OP_MAX;
         2: return -OP_MAX;
         3: return OPERAND_W'($urandom_range(0, 6) - 3);
         default: return OPERAND_W'($urandom());
      endcase
   endfunction

   // Idle percentages per phase: none, sender only, receiver only, both.
   function automatic int sender_idle_pct(int count);
      case ((count / PHASE_LEN) % 4)
         1: return 48;
         3: return 26;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct(int count);
      case ((count / PHASE_LEN) % 4)
         2: return 48;
         3: return 26;
         default: return 0;
      endcase
   endfunction

   task automatic queue_request(logic [MODE_W-1:0] mode,
                                logic signed [OPERAND_W-1:0] xr, xi, yr, yi,
                                logic [EXP_W-1:0] e);
      alu_request_type rq;
      rq.mode = mode;
      rq.x_re = xr;
      rq.x_im = xi;
      rq.y_re = yr;
      rq.y_im = yi;
      rq.exponent = e;
      // Now and then the sender waits for the block to empty completely.
      rq.drain_first = (pending_requests.size() > 0) &&
                       (pending_requests.size() % PHASE_LEN == 0);
      pending_requests.push_back(rq);
   endtask

   task automatic check_field(string name, logic signed [RES_W-1:0] expected,
                              logic signed [RES_W-1:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                  expected, actual);
         failed = 1'b1;
      end
   endtask

   // Driver: when the channel is free, present the next pending beat unless the sender idles or waits for a drain.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(predict_alu(current_request));
            issued_count++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() > 0 &&
                !(pending_requests[0].drain_first && expected_results.size() > 0) &&
                $urandom_range(0, 99) >= sender_idle_pct(issued_count)) begin
               current_request = pending_requests.pop_front();
               req_mode     <= current_request.mode;
               req_x_re     <= current_request.x_re;
               req_x_im     <= current_request.x_im;
               req_y_re     <= current_request.y_re;
               req_y_im     <= current_request.y_im;
               req_exponent <= current_request.exponent;
               req_valid    <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted result beat with the oldest prediction.
   always @(posedge clock) begin
      alu_result_type exp_result;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result beat with no prediction pending, re %0d im %0d",
                        $time, rsp_res_re, rsp_res_im);
               failed = 1'b1;
            end else begin
               exp_result = expected_results.pop_front();
               check_field("res_re", exp_result.re, rsp_res_re);
               check_field("res_im", exp_result.im, rsp_res_im);
               check_field("div_by_zero", RES_W'(exp_result.div_by_zero),
                           RES_W'(rsp_div_by_zero));
            end
            returned_count++;
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct(returned_count));
      end
   end

   initial begin
      logic [MODE_W-1:0] mode;
      logic [EXP_W-1:0]  e;
      logic signed [OPERAND_W-1:0] yr, yi;

      queue_request(MODE_ADD, OP_MAX, OP_MAX, OP_MAX, OP_MAX, 8'd255);
      queue_request(MODE_ADD, OP_MIN, OP_MIN, OP_MIN, OP_MIN, 8'd0);
      queue_request(MODE_SUB, OP_MIN, OP_MIN, OP_MAX, OP_MAX, 8'd1);
      queue_request(MODE_SUB, OP_MAX, -16'sd5, OP_MIN, 16'sd9, 8'd128);
      queue_request(MODE_MUL, OP_MIN, OP_MIN, OP_MIN, OP_MIN, 8'd0);
      queue_request(MODE_MUL, OP_MAX, OP_MIN, -16'sd3, OP_MAX, 8'd7);
      queue_request(MODE_DIV, 16'sd100, 16'sd50, 16'sd0, 16'sd0, 8'd0);
      queue_request(MODE_DIV, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0);
      queue_request(MODE_DIV, 16'sd100, 16'sd50, 16'sd3, 16'sd4, 8'd0);
      queue_request(MODE_DIV, -16'sd7, 16'sd7, 16'sd2, 16'sd0, 8'd0);
      queue_request(MODE_DIV, OP_MIN, OP_MIN, 16'sd1, 16'sd0, 8'd0);
      queue_request(MODE_DIV, OP_MIN, OP_MAX, OP_MIN, OP_MIN, 8'd0);
      queue_request(MODE_DIV, 16'sd1, -16'sd1, OP_MAX, OP_MAX, 8'd255);
      queue_request(MODE_POW, 16'sd3, 16'sd2, 16'sd0, 16'sd0, 8'd0);
      queue_request(MODE_POW, -16'sd3, 16'sd2, 16'sd0, 16'sd0, 8'd1);
      queue_request(MODE_POW, 16'sd3, -16'sd2, OP_MAX, OP_MIN, 8'd2);
      queue_request(MODE_POW, OP_MAX, OP_MAX, 16'sd0, 16'sd0, 8'd3);
      queue_request(MODE_POW, 16'sd3, 16'sd2, 16'sd0, 16'sd0, 8'd255);
      queue_request(MODE_POW, OP_MIN, OP_MIN, 16'sd0, 16'sd0, 8'd255);
      for (int m = MODE_RSVD_FIRST; m <= MODE_RSVD_LAST; m++)
         queue_request(MODE_W'(m), OP_MAX, OP_MIN, -16'sd1, 16'sd1, 8'd255);

      repeat (RANDOM_BEATS) begin
         if ($urandom_range(0, 49) == 0)
            mode = MODE_W'($urandom_range(MODE_RSVD_FIRST, MODE_RSVD_LAST));
         else
            mode = MODE_W'($urandom_range(MODE_ADD, MODE_POW));
         if ($urandom_range(0, 3) == 0)
            e = EXP_W'($urandom_range(0, 4));
         else
            e = EXP_W'($urandom_range(0, 255));
         yr = pick_operand();
         yi = pick_operand();
         // A zero divisor is rare at random, so force it now and then.
         if (mode == MODE_DIV && $urandom_range(0, 9) == 0) begin
            yr = '0;
            yi = '0;
         end
         queue_request(mode, pick_operand(), pick_operand(), yr, yi, e);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (!failed && expected_results.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #5000000;
      $display("timeout with %0d beats pending and %0d results outstanding",
               pending_requests.size(), expected_results.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

/* complex_integer_alu.f */
src/cia_pkg.sv
src/cia_div.sv
src/complex_integer_alu.sv
tb/sv/complex_integer_alu_test.sv
